>>> rtl/hashed_multi_fifo_assert.svh
// Assertion macros shared by the hashed multi-queue FIFO RTL.
// Needs nothing but a clock and a synchronous active-high reset at the point of use.
`ifndef HASHED_MULTI_FIFO_ASSERT_SVH
`define HASHED_MULTI_FIFO_ASSERT_SVH

// same-cycle implication, off while reset is high
`define HMF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while reset is high
`define HMF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/hmf_pkg.sv
// Types and constants for the hashed multi-queue FIFO.
// Standalone package; used by hashed_multi_fifo.
package hmf_pkg;

   localparam int WORD_W     = 64;
   localparam int HASH_SHIFT = 4;
   localparam int HASH_ROT   = WORD_W - HASH_SHIFT;

   // remainder of the hash is taken one nibble per cycle
   localparam int DIGIT_W    = 4;
   localparam int DIGITS     = WORD_W / DIGIT_W;
   localparam int DIGIT_CW   = $clog2(DIGITS);

   localparam int STATUS_W   = 2;
   localparam int USED_W     = 2;
   localparam int RSP_DATA_W = 72;   // word_out + queue_used, padded to bytes
   localparam int RSP_PAD_W  = RSP_DATA_W - WORD_W - USED_W;

   typedef logic [WORD_W-1:0]   word_type;
   typedef logic [STATUS_W-1:0] status_type;

   // operation selector on req_tuser
   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_POP  = 1'b1;

   // result status codes
   localparam status_type STAT_DONE  = 2'd0;
   localparam status_type STAT_FULL  = 2'd1;
   localparam status_type STAT_EMPTY = 2'd2;

endpackage

>>> rtl/hashed_multi_fifo.sv
// Hashed multi-queue FIFO: QUEUES ring FIFOs of 64-bit words with hash steering on push
// and round-robin pop. Depends on hmf_pkg and hashed_multi_fifo_assert.svh.

// A push takes one beat on req with req_tuser = 0 and the word in req_tdata. The word is
// steered to queue ((w >> 4) ^ (w << 60)) mod QUEUES and appended there, or rejected with
// status 1 when that queue holds DEPTH words. A pop (req_tuser = 1) scans the queues one
// per cycle, starting one past the queue served last, and returns the head of the first
// non-empty queue, or status 2 with a zero word when all are empty. Every request gives
// exactly one rsp beat. Items are handled one at a time, and req_tready is low while an
// item is in work. A push passes through ST_PUSH, which registers the result, when
// QUEUES is a power of two. Otherwise it first passes through ST_HASH, where the remainder
// unit reduces the hash one nibble per cycle. A pop passes through ST_SCAN, which checks
// one fill counter per cycle, and then ST_READ, because the slot memory read is
// registered; a pop that finds every queue empty answers straight from ST_SCAN.
// req_tready rises in the same cycle as rsp_tvalid.
// A result waiting on rsp does not stop the next request from being accepted and worked
// up to the point where its own result is ready.
module hashed_multi_fifo #(
   parameter int QUEUES = 4,
   parameter int DEPTH  = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [hmf_pkg::WORD_W-1:0]      req_tdata,   // [63:0] word_in
   input  logic [0:0]                      req_tuser,   // [0] mode
   // result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [hmf_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // [63:0] word_out, [65:64] queue_used
   output logic [hmf_pkg::STATUS_W-1:0]    rsp_tuser    // [1:0] status
);

`include "hashed_multi_fifo_assert.svh"

   localparam int QW     = (QUEUES > 1) ? $clog2(QUEUES) : 1;
   localparam int DW     = $clog2(DEPTH);
   localparam int FW     = DW + 1;
   localparam int AW     = QW + DW;
   localparam int LUT_N  = 2 ** (QW + hmf_pkg::DIGIT_W);
   localparam bit Q_POW2 = ((QUEUES & (QUEUES - 1)) == 0);

   localparam logic [QW-1:0]                Q_LAST     = QW'(QUEUES - 1);
   localparam logic [DW-1:0]                P_LAST     = DW'(DEPTH - 1);
   localparam logic [FW-1:0]                FILL_FULL  = FW'(DEPTH);
   localparam logic [hmf_pkg::DIGIT_CW-1:0] DIGIT_LAST = hmf_pkg::DIGIT_CW'(hmf_pkg::DIGITS - 1);

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_HASH = 3'd1;
   localparam logic [2:0] ST_PUSH = 3'd2;
   localparam logic [2:0] ST_SCAN = 3'd3;
   localparam logic [2:0] ST_READ = 3'd4;

   // control state
   logic [2:0]                    state_ff, state_in;
   logic [QW-1:0]                 qsel_ff, qsel_in;
   logic [QW-1:0]                 last_ff, last_in;
   logic [QW-1:0]                 scan_cnt_ff, scan_cnt_in;
   logic [hmf_pkg::DIGIT_CW-1:0]  digit_cnt_ff, digit_cnt_in;
   logic [QW-1:0]                 rem_ff, rem_in;
   logic [DW-1:0]                 wr_ptr_ff [QUEUES];
   logic [DW-1:0]                 wr_ptr_in [QUEUES];
   logic [DW-1:0]                 rd_ptr_ff [QUEUES];
   logic [DW-1:0]                 rd_ptr_in [QUEUES];
   logic [FW-1:0]                 fill_ff [QUEUES];
   logic [FW-1:0]                 fill_in [QUEUES];
   logic                          rsp_valid_ff, rsp_valid_in;

   // payload
   hmf_pkg::word_type             word_ff, word_in;
   hmf_pkg::word_type             hash_ff, hash_in;
   hmf_pkg::word_type             rsp_word_ff, rsp_word_in;
   hmf_pkg::status_type           rsp_status_ff, rsp_status_in;
   logic [hmf_pkg::USED_W-1:0]    rsp_used_ff, rsp_used_in;

   // slot memory
   hmf_pkg::word_type             slot_mem_ff [2**AW];
   hmf_pkg::word_type             mem_rdata_ff;
   logic                          mem_we, mem_re;
   logic [AW-1:0]                 mem_addr;

   // remainder table: entry {r, nibble} holds ({r, nibble}) mod QUEUES
   logic [QW-1:0]                 mod_lut [LUT_N];
   for (genvar g = 0; g < LUT_N; g++) begin : g_lut
      assign mod_lut[g] = QW'(g % QUEUES);
   end

   hmf_pkg::word_type             req_hash;
   logic                          out_free;
   logic [QW-1:0]                 qsel_next;
   logic [QW-1:0]                 last_next;
   logic [DW-1:0]                 wr_ptr_cur, rd_ptr_cur;
   logic [FW-1:0]                 fill_cur;

   assign req_hash   = (req_tdata >> hmf_pkg::HASH_SHIFT) ^ (req_tdata << hmf_pkg::HASH_ROT);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign qsel_next  = (qsel_ff == Q_LAST) ? '0 : qsel_ff + 1'b1;
   assign last_next  = (last_ff == Q_LAST) ? '0 : last_ff + 1'b1;
   assign wr_ptr_cur = wr_ptr_ff[qsel_ff];
   assign rd_ptr_cur = rd_ptr_ff[qsel_ff];
   assign fill_cur   = fill_ff[qsel_ff];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{hmf_pkg::RSP_PAD_W{1'b0}}, rsp_used_ff, rsp_word_ff};
   assign rsp_tuser  = rsp_status_ff;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      qsel_in       = qsel_ff;
      last_in       = last_ff;
      scan_cnt_in   = scan_cnt_ff;
      digit_cnt_in  = digit_cnt_ff;
      rem_in        = rem_ff;
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      fill_in       = fill_ff;
      word_in       = word_ff;
      hash_in       = hash_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_status_in = rsp_status_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_addr      = {qsel_ff, wr_ptr_cur};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               word_in      = req_tdata;
               hash_in      = req_hash;
               rem_in       = '0;
               digit_cnt_in = '0;
               scan_cnt_in  = '0;
               if (req_tuser[0] == hmf_pkg::MODE_POP) begin
                  qsel_in  = last_next;
                  state_in = ST_SCAN;
               end else if (Q_POW2) begin
                  qsel_in  = QW'(req_hash) & Q_LAST;
                  state_in = ST_PUSH;
               end else begin
                  state_in = ST_HASH;
               end
            end
         end

         // one nibble of the hash per cycle, most significant first
         ST_HASH: begin
            rem_in       = mod_lut[{rem_ff, hash_ff[hmf_pkg::WORD_W-1 -: hmf_pkg::DIGIT_W]}];
            hash_in      = hash_ff << hmf_pkg::DIGIT_W;
            digit_cnt_in = digit_cnt_ff + 1'b1;
            if (digit_cnt_ff == DIGIT_LAST) begin
               qsel_in  = rem_in;
               state_in = ST_PUSH;
            end
         end

         // append to the steered queue, or reject when full
         ST_PUSH: begin
            if (out_free) begin
               rsp_word_in  = '0;
               rsp_used_in  = hmf_pkg::USED_W'(qsel_ff);
               rsp_valid_in = 1'b1;
               if (fill_cur == FILL_FULL) begin
                  rsp_status_in = hmf_pkg::STAT_FULL;
               end else begin
                  rsp_status_in      = hmf_pkg::STAT_DONE;
                  mem_we             = 1'b1;
                  wr_ptr_in[qsel_ff] = (wr_ptr_cur == P_LAST) ? '0 : wr_ptr_cur + 1'b1;
                  fill_in[qsel_ff]   = fill_cur + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end

         // round-robin scan, one queue per cycle
         ST_SCAN: begin
            mem_addr = {qsel_ff, rd_ptr_cur};
            if (fill_cur != '0) begin
               mem_re             = 1'b1;
               rd_ptr_in[qsel_ff] = (rd_ptr_cur == P_LAST) ? '0 : rd_ptr_cur + 1'b1;
               fill_in[qsel_ff]   = fill_cur - 1'b1;
               last_in            = qsel_ff;
               state_in           = ST_READ;
            end else if (scan_cnt_ff == Q_LAST) begin
               if (out_free) begin
                  rsp_word_in   = '0;
                  rsp_status_in = hmf_pkg::STAT_EMPTY;
                  rsp_used_in   = '0;
                  rsp_valid_in  = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else begin
               qsel_in     = qsel_next;
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end
         end

         // memory data is back; present the popped word
         ST_READ: begin
            if (out_free) begin
               rsp_word_in   = mem_rdata_ff;
               rsp_status_in = hmf_pkg::STAT_DONE;
               rsp_used_in   = hmf_pkg::USED_W'(qsel_ff);
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < QUEUES; i++) begin
            wr_ptr_ff[i] <= '0;
            rd_ptr_ff[i] <= '0;
            fill_ff[i]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         fill_ff      <= fill_in;
      end
   end

   // payload and sequencer working registers
   always_ff @(posedge clock) begin
      qsel_ff       <= qsel_in;
      scan_cnt_ff   <= scan_cnt_in;
      digit_cnt_ff  <= digit_cnt_in;
      rem_ff        <= rem_in;
      word_ff       <= word_in;
      hash_ff       <= hash_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_status_ff <= rsp_status_in;
      rsp_used_ff   <= rsp_used_in;
   end

   // slot memory, one port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem_ff[mem_addr] <= word_ff;
      end
      if (mem_re) begin
         mem_rdata_ff <= slot_mem_ff[mem_addr];
      end
   end

   // checks
   `HMF_ASSERT_NOW(a_push_queue_range, clock, reset, state_ff == ST_PUSH,
      qsel_ff <= Q_LAST, "push steered past the last queue")
   `HMF_ASSERT_NOW(a_read_sets_last, clock, reset, state_ff == ST_READ,
      last_ff == qsel_ff, "served queue not recorded as last tried")
   `HMF_ASSERT_NOW(a_empty_zero_word, clock, reset,
      rsp_valid_ff && (rsp_status_ff != hmf_pkg::STAT_DONE),
      rsp_word_ff == '0, "rejected request returned a nonzero word")
   `HMF_ASSERT_NEXT(a_push_fill_up, clock, reset,
      (state_ff == ST_PUSH) && out_free && (fill_cur != FILL_FULL),
      fill_ff[$past(qsel_ff)] == $past(fill_cur) + 1'b1, "fill count not advanced by push")

endmodule
